FILE: rtl/fqsc_pkg.sv
`default_nettype none

package fqsc_pkg;

    // Default sizing of the queue; the top level takes these as parameter defaults.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    // Fixed widths of the command and result fields.
    localparam int VALUE_W   = 32;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Control from the sequencer to the shared compare and count unit.
    typedef struct packed {
        logic clear;
        logic enable;
    } match_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/fifo_queue_with_search_count.sv
`default_nettype none

// Bounded first-in first-out queue of signed values with an occurrence search.
// A command beat is taken at a rising edge where start is high and busy is low;
// operation selects push, pop of the oldest entry, search for a key, or clear.
// Every command gives exactly one result beat: done is high for one cycle and
// popped_value, found, match_count, queue_size and status are valid with it.
// The receiver cannot hold a result off, so the block never waits on it.
// How each operation completes, counted from the accepting edge:
//   push, clear, pop on an empty queue, search on an empty queue: done in the
//   next cycle and busy is never raised, so one command per cycle.
//   pop: done waits on the registered read port of the entry store.
//   search over n held entries: the store is read one entry a cycle and a
//   single compare and count unit checks each entry as it returns.
// After reset the queue is empty (head, tail and count cleared); the entry
// store itself is not cleared, since only entries that were pushed are read.
module fifo_queue_with_search_count
    import fqsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  operation,
    input  wire logic signed [VALUE_W-1:0]   value,
    output logic                             done,
    output logic signed [VALUE_W-1:0]        popped_value,
    output logic                             found,
    output logic [OUT_CNT_W-1:0]             match_count,
    output logic [OUT_CNT_W-1:0]             queue_size,
    output logic [1:0]                       status
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_DATA,
        S_SEARCH
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          scan_reg, scan_next;
    logic [CNT_W-1:0]          left_reg, left_next;
    logic [DATA_WIDTH-1:0]     key_reg, key_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic                      done_reg, done_next;
    logic [VALUE_W-1:0]        popped_reg, popped_next;
    logic                      found_reg, found_next;
    logic [CNT_W-1:0]          match_reg, match_next;
    status_t                   status_reg, status_next;

    logic                      accept;
    op_t                       op;
    logic [DATA_WIDTH-1:0]     value_bits;
    logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
    logic [DATA_WIDTH+VALUE_W-1:0] popped_ext;
    logic [CNT_W+OUT_CNT_W-1:0]    size_ext;
    logic [CNT_W+OUT_CNT_W-1:0]    match_ext;

    logic                      wr_en;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [DATA_WIDTH-1:0]     rd_data;
    match_ctrl_t               mctrl;
    logic [CNT_W-1:0]          unit_count;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    assign accept = start && !busy;
    assign op     = op_t'(operation);

    // Only the low DATA_WIDTH bits of the value are stored and compared; a
    // wider store is filled with zeros above the value field.
    assign value_ext  = {{DATA_WIDTH{1'b0}}, value};
    assign value_bits = value_ext[DATA_WIDTH-1:0];

    // A popped entry is sign-extended from DATA_WIDTH bits and cut to the port.
    assign popped_ext = {{VALUE_W{rd_data[DATA_WIDTH-1]}}, rd_data};

    fqsc_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (value_bits),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fqsc_match #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mctrl),
        .key   (key_reg),
        .data  (rd_data),
        .count (unit_count)
    );

    // While idle the read port points at the head, ready for a pop or the
    // first entry of a search; during a search it follows the scan pointer.
    assign rd_addr = (state_reg == S_IDLE) ? head_reg : scan_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        left_next     = left_reg;
        key_next      = key_reg;
        rd_valid_next = 1'b0;
        done_next     = 1'b0;
        popped_next   = popped_reg;
        found_next    = found_reg;
        match_next    = match_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        mctrl.clear   = 1'b0;
        mctrl.enable  = rd_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    found_next  = 1'b0;
                    match_next  = '0;
                    status_next = ST_OK;
                    unique case (op)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == DEPTH_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = next_idx(tail_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_POP_DATA;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // First read goes out now; the rest follow.
                                rd_en         = 1'b1;
                                rd_valid_next = 1'b1;
                                mctrl.clear   = 1'b1;
                                key_next      = value_bits;
                                scan_next     = next_idx(head_reg);
                                left_next     = count_reg - CNT_W'(1);
                                state_next    = S_SEARCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_DATA:
            begin
                popped_next = popped_ext[VALUE_W-1:0];
                head_next   = next_idx(head_reg);
                count_next  = count_reg - CNT_W'(1);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_SEARCH:
            begin
                if (left_reg != '0)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    scan_next     = next_idx(scan_reg);
                    left_next     = left_reg - CNT_W'(1);
                end
                else if (!rd_valid_reg)
                begin
                    // The last entry was counted at the previous edge.
                    match_next = unit_count;
                    found_next = (unit_count != '0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            left_reg     <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            match_reg    <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            left_reg     <= left_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            match_reg    <= match_next;
            status_reg   <= status_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        popped_reg <= popped_next;
    end

    // Counts are reported in a fixed five-bit field.
    assign size_ext  = {{OUT_CNT_W{1'b0}}, count_reg};
    assign match_ext = {{OUT_CNT_W{1'b0}}, match_reg};

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign match_count  = match_ext[OUT_CNT_W-1:0];
    assign queue_size   = size_ext[OUT_CNT_W-1:0];
    assign status       = status_reg;

endmodule

`default_nettype wire

FILE: rtl/fqsc_ram.sv
`default_nettype none

module fqsc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data is registered; it appears in the cycle after the request.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fqsc_match.sv
`default_nettype none

module fqsc_match
    import fqsc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire match_ctrl_t                ctrl,
    input  wire logic [WIDTH-1:0]           key,
    input  wire logic [WIDTH-1:0]           data,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // One equality compare, reused for every entry of a search.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.enable && (data == key))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

FILE: rtl/fqsc_checker.sv
`default_nettype none

module fqsc_checker
    import fqsc_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic [1:0]                operation,
    input wire logic signed [VALUE_W-1:0] value,
    input wire logic                      done,
    input wire logic signed [VALUE_W-1:0] popped_value,
    input wire logic                      found,
    input wire logic [OUT_CNT_W-1:0]      match_count,
    input wire logic [OUT_CNT_W-1:0]      queue_size,
    input wire logic [1:0]                status
);

    // A result beat only ever follows an accepted command or a busy cycle.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result beat without a command in progress");

    // The block is free again whenever it delivers a result.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high with the result beat");

    // A pop on an empty queue leaves nothing held and returns zero.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> ((queue_size == '0) && (popped_value == '0)))
        else $error("empty status with a held entry or a non-zero value");

    // No match reported means a zero count.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (match_count == '0))
        else $error("match count set without a match");

    // Status carries only its three defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY)))
        else $error("undefined status code");

endmodule

bind fifo_queue_with_search_count fqsc_checker u_fqsc_checker (.*);

`default_nettype wire
